// ===== hdl/ames_pkg.sv =====
package ames_pkg;

  localparam logic [6:0] OP_READ  = 7'h10;
  localparam logic [6:0] OP_WRITE = 7'h11;
  localparam logic [6:0] OP_LOAD  = 7'h20;
  localparam logic [6:0] OP_STORE = 7'h21;
  localparam logic [6:0] OP_ADD   = 7'h30;
  localparam logic [6:0] OP_SUB   = 7'h31;
  localparam logic [6:0] OP_DIV   = 7'h32;
  localparam logic [6:0] OP_MUL   = 7'h33;
  localparam logic [6:0] OP_JUMP  = 7'h40;
  localparam logic [6:0] OP_JNEG  = 7'h41;
  localparam logic [6:0] OP_JZERO = 7'h42;
  localparam logic [6:0] OP_HALT  = 7'h43;
  localparam logic [6:0] OP_XOR   = 7'h54;
  localparam logic [6:0] OP_JPOS  = 7'h55;
  localparam logic [6:0] OP_SHL   = 7'h67;
  localparam logic [6:0] OP_SHR   = 7'h68;

  localparam logic signed [15:0] WORD_MAX     = 16'sh7FFF;
  localparam logic signed [15:0] WORD_MIN_RAW = 16'sh8000;
  localparam logic signed [32:0] WIDE_MAX     = 33'sd32767;
  localparam logic signed [32:0] WIDE_MIN     = -33'sd32767;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DECODE  = 3'd1,
    ST_OPERAND = 3'd2,
    ST_COUNTER = 3'd3,
    ST_ARITH   = 3'd4,
    ST_DIVZERO = 3'd5,
    ST_HALT    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ALU,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [6:0]          cmd;
    logic [6:0]          operand;
    logic                decode_ok;
    logic signed [15:0]  read_value;
  } in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic                stopped;
    logic [6:0]          next_counter;
    logic signed [15:0]  acc_value;
    logic                write_valid;
    logic signed [15:0]  write_value;
  } out_t;

  typedef struct packed {
    logic       start;
    logic [6:0] op;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    status_t            status;
    logic signed [15:0] result;
  } alu_rsp_t;

  function automatic logic is_arith(input logic [6:0] op);
    return (op == OP_ADD) || (op == OP_SUB) || (op == OP_DIV) || (op == OP_MUL) ||
           (op == OP_XOR) || (op == OP_SHL) || (op == OP_SHR);
  endfunction

endpackage

// ===== hdl/accumulator_machine_execute_step_top.sv =====
// Executes one decoded instruction of an accumulator machine per input transfer and returns
// one result transfer with status, counter, accumulator and printed word. Memory, accumulator
// and instruction counter live inside; memory reads zero after reset through per-word valid
// bits, so no clearing pass is needed. Moves, jumps, halt and failed checks go from execute to
// finish directly; add, sub, mul, xor and shifts pass once through the shared arithmetic unit
// in between, and a divide by a nonzero word runs the 16 steps of the bit-serial divider. The
// input is stalled while an item is in progress; a finished result waits in the output
// register without blocking the next item until its own result is ready.
module accumulator_machine_execute_step_top #(
  parameter int MEM_WORDS = 100
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ames_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ames_pkg::out_t  out_data
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [7:0] WORDS8 = 8'(MEM_WORDS);
  localparam logic [7:0] LAST8  = 8'(MEM_WORDS - 1);

  ames_pkg::state_t   state_r, state_nxt;
  logic [6:0]         cmd_r, opd_r;
  logic               ok_r;
  logic signed [15:0] rv_r;
  logic signed [15:0] mrd_r;
  logic signed [15:0] acc_r, acc_nxt;
  logic [6:0]         ctr_r, ctr_nxt;
  ames_pkg::status_t  st_r, st_nxt;
  logic               wv_r, wv_nxt;
  logic signed [15:0] wval_r, wval_nxt;
  logic               out_valid_r, out_valid_nxt;
  ames_pkg::out_t     out_r, out_nxt;

  logic signed [15:0] mem_r [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic               mem_we;
  logic signed [15:0] mem_wdata;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               in_xfer;

  ames_pkg::alu_req_t alu_req;
  ames_pkg::alu_rsp_t alu_rsp;

  logic               adv;
  logic               take_jump;

  assign in_stall = (state_r != ames_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign rd_addr  = ({1'b0, in_data.operand} < WORDS8) ? in_data.operand[AW-1:0] : '0;
  assign wr_addr  = opd_r[AW-1:0];

  ames_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .acc   (acc_r),
    .mem   (mrd_r),
    .rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= mem_wdata;
    end
    if (in_xfer) begin
      mrd_r <= vld_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    ctr_nxt       = ctr_r;
    st_nxt        = st_r;
    wv_nxt        = wv_r;
    wval_nxt      = wval_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wdata     = acc_r;
    alu_req.start = 1'b0;
    alu_req.op    = cmd_r;
    adv           = 1'b1;
    take_jump     = 1'b0;

    unique case (state_r)
      ames_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = ames_pkg::S_EXEC;
        end
      end
      ames_pkg::S_EXEC: begin
        state_nxt = ames_pkg::S_FIN;
        st_nxt    = ames_pkg::ST_OK;
        wv_nxt    = 1'b0;
        wval_nxt  = '0;
        priority if (!ok_r) begin
          st_nxt = ames_pkg::ST_DECODE;
        end else if ({1'b0, opd_r} >= WORDS8) begin
          st_nxt = ames_pkg::ST_OPERAND;
        end else if ({1'b0, ctr_r} >= LAST8) begin
          st_nxt  = ames_pkg::ST_COUNTER;
          ctr_nxt = '0;
        end else if (ames_pkg::is_arith(cmd_r)) begin
          alu_req.start = 1'b1;
          state_nxt     = ames_pkg::S_ALU;
        end else begin
          unique case (cmd_r)
            ames_pkg::OP_READ: begin
              mem_we    = 1'b1;
              mem_wdata = (rv_r == ames_pkg::WORD_MIN_RAW) ? -ames_pkg::WORD_MAX : rv_r;
            end
            ames_pkg::OP_WRITE: begin
              wv_nxt   = 1'b1;
              wval_nxt = mrd_r;
            end
            ames_pkg::OP_LOAD:  acc_nxt = mrd_r;
            ames_pkg::OP_STORE: mem_we = 1'b1;
            ames_pkg::OP_JUMP:  take_jump = 1'b1;
            ames_pkg::OP_JNEG:  take_jump = acc_r < 0;
            ames_pkg::OP_JZERO: take_jump = acc_r == 0;
            ames_pkg::OP_JPOS:  take_jump = acc_r > 0;
            ames_pkg::OP_HALT: begin
              st_nxt = ames_pkg::ST_HALT;
              adv    = 1'b0;
            end
            default: ;
          endcase
          if (take_jump) begin
            ctr_nxt = opd_r;
          end else if (adv) begin
            ctr_nxt = ctr_r + 7'd1;
          end
        end
      end
      ames_pkg::S_ALU: begin
        if (alu_rsp.done) begin
          st_nxt    = alu_rsp.status;
          state_nxt = ames_pkg::S_FIN;
          if (alu_rsp.status == ames_pkg::ST_OK) begin
            acc_nxt = alu_rsp.result;
            ctr_nxt = ctr_r + 7'd1;
          end
        end
      end
      ames_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = st_r;
          out_nxt.stopped      = (st_r != ames_pkg::ST_OK);
          out_nxt.next_counter = ctr_r;
          out_nxt.acc_value    = acc_r;
          out_nxt.write_valid  = wv_r;
          out_nxt.write_value  = wval_r;
          state_nxt            = ames_pkg::S_IDLE;
        end
      end
      default: state_nxt = ames_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ames_pkg::S_IDLE;
      acc_r       <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_data.cmd;
      opd_r <= in_data.operand;
      ok_r  <= in_data.decode_ok;
      rv_r  <= in_data.read_value;
    end
    st_r   <= st_nxt;
    wv_r   <= wv_nxt;
    wval_r <= wval_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/ames_alu.sv =====
module ames_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  ames_pkg::alu_req_t  req,
  input  logic signed [15:0]  acc,
  input  logic signed [15:0]  mem,
  output ames_pkg::alu_rsp_t  rsp
);

  logic               busy_r, busy_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [15:0]        quo_r, quo_nxt;
  logic [15:0]        dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  ames_pkg::alu_rsp_t rsp_r, rsp_nxt;

  logic signed [31:0] prod;
  logic signed [32:0] a_w, m_w, wide;
  logic signed [15:0] shr_v;
  logic [16:0]        rem_sh, diff;
  logic [15:0]        quo_sh;
  logic               qbit;

  assign prod  = acc * mem;
  assign a_w   = $signed({{17{acc[15]}}, acc});
  assign m_w   = $signed({{17{mem[15]}}, mem});
  assign shr_v = mem >>> acc[3:0];

  always_comb begin
    unique case (req.op)
      ames_pkg::OP_ADD: wide = a_w + m_w;
      ames_pkg::OP_SUB: wide = a_w - m_w;
      ames_pkg::OP_MUL: wide = $signed({prod[31], prod});
      ames_pkg::OP_XOR: wide = $signed({{17{acc[15] ^ mem[15]}}, acc ^ mem});
      ames_pkg::OP_SHL: wide = m_w <<< acc[3:0];
      ames_pkg::OP_SHR: wide = $signed({{17{shr_v[15]}}, shr_v});
      default:          wide = '0;
    endcase
  end

  // restoring divide step on magnitudes
  assign rem_sh = {rem_r, quo_r[15]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign qbit   = ~diff[16];
  assign quo_sh = {quo_r[14:0], qbit};

  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dvs_nxt     = dvs_r;
    neg_nxt     = neg_r;
    rsp_nxt     = rsp_r;
    rsp_nxt.done = 1'b0;
    if (req.start) begin
      if (req.op == ames_pkg::OP_DIV) begin
        if (mem == '0) begin
          rsp_nxt.done   = 1'b1;
          rsp_nxt.status = ames_pkg::ST_DIVZERO;
          rsp_nxt.result = '0;
        end else begin
          busy_nxt = 1'b1;
          cnt_nxt  = '0;
          rem_nxt  = '0;
          quo_nxt  = acc[15] ? 16'(-acc) : acc;
          dvs_nxt  = mem[15] ? 16'(-mem) : mem;
          neg_nxt  = acc[15] ^ mem[15];
        end
      end else begin
        rsp_nxt.done   = 1'b1;
        rsp_nxt.result = wide[15:0];
        if ((req.op == ames_pkg::OP_SHL || req.op == ames_pkg::OP_SHR) && acc[15:4] != '0) begin
          rsp_nxt.status = ames_pkg::ST_ARITH;
        end else if (wide > ames_pkg::WIDE_MAX || wide < ames_pkg::WIDE_MIN) begin
          rsp_nxt.status = ames_pkg::ST_ARITH;
        end else begin
          rsp_nxt.status = ames_pkg::ST_OK;
        end
      end
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[15:0] : rem_sh[15:0];
      quo_nxt = quo_sh;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt       = 1'b0;
        rsp_nxt.done   = 1'b1;
        rsp_nxt.status = ames_pkg::ST_OK;
        rsp_nxt.result = neg_r ? 16'(-quo_sh) : quo_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      rsp_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      rsp_r    <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp = rsp_r;

endmodule
